// File: rtl/cir_pkg.sv
// Shared types, codes and saturation helpers for the contact impulse resolver.
`default_nettype none
package cir_pkg;

  localparam int BODY_COUNT_DEF = 256;
  localparam logic [16:0] THR_RESET = 17'd328;
  localparam logic signed [32:0] Q_ONE = 33'sd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    CMD_WR_VEL  = 2'd0,
    CMD_WR_PROP = 2'd1,
    CMD_CONTACT = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OC_READ = 2'd0,
    OC_SEP  = 2'd1,
    OC_REFL = 2'd2,
    OC_FRIC = 2'd3
  } oc_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RDB, ST_LATB, ST_G, ST_DN, ST_DNG, ST_JM, ST_JDIV, ST_DJ,
    ST_PUSHA, ST_PUSHB, ST_TAN, ST_SQ, ST_SQRT, ST_TDIV, ST_DOT, ST_JTDIV,
    ST_LIM, ST_FR1, ST_FR2, ST_WBA, ST_WBB, ST_OUTA, ST_OUTB
  } state_e;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vel_t;

  typedef struct packed {
    logic        movable;
    logic [17:0] df;
    logic [17:0] sf;
    logic [16:0] rest;
    logic [30:0] mass;
  } prop_t;

  typedef struct packed {
    logic               start;
    logic               sqrt;
    logic signed [31:0] num;
    logic [31:0]        den;
    logic [63:0]        rad;
  } itu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
  } itu_rsp_t;

  function automatic logic signed [34:0] sx35(input logic signed [31:0] x);
    return {{3{x[31]}}, x};
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
      return x[31:0];
    end else if (x[34]) begin
      return S32_MIN;
    end
    return S32_MAX;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cir_mul.sv
// Shared registered multiplier with Q16.16 floor and saturation.
`default_nettype none
module cir_mul
  import cir_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [31:0]      q_o,
  output logic [63:0]             raw_o
);

  logic signed [65:0] prod_q;
  logic signed [49:0] shr;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign shr = prod_q[65:16];
  assign raw_o = prod_q[63:0];

  always_comb begin
    if ((&shr[49:31]) || !(|shr[49:31])) begin
      q_o = shr[31:0];
    end else if (shr[49]) begin
      q_o = S32_MIN;
    end else begin
      q_o = S32_MAX;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cir_itu.sv
// Iterative unit: restoring Q16.16 divide (48 steps) or integer square root (32 steps).
`default_nettype none
module cir_itu
  import cir_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire itu_req_t req_i,
  output itu_rsp_t      rsp_o
);

  logic               busy_q, done_q, sqrt_q, neg_q, zero_q;
  logic [5:0]         cnt_q;
  logic [34:0]        rem_q;
  logic [63:0]        sh_q;
  logic [31:0]        root_q, den_q, mag;
  logic signed [31:0] res_q, fin;
  logic [32:0]        r2d;
  logic               ged;
  logic [34:0]        r2s, trial;
  logic               ges;
  logic [47:0]        q48;

  assign mag = req_i.num[31] ? (~req_i.num + 32'd1) : req_i.num;
  assign r2d = {rem_q[31:0], sh_q[63]};
  assign ged = r2d >= {1'b0, den_q};
  assign r2s = {rem_q[32:0], sh_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ges = r2s >= trial;
  assign q48 = sh_q[47:0];

  always_comb begin
    if (sqrt_q) begin
      fin = root_q[31] ? S32_MAX : root_q;
    end else if (zero_q) begin
      fin = '0;
    end else if (neg_q) begin
      fin = (q48 > 48'h0000_8000_0000) ? S32_MIN : (~q48[31:0] + 32'd1);
    end else begin
      fin = (q48 > 48'h0000_7fff_ffff) ? S32_MAX : q48[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.sqrt ? 6'd32 : 6'd48;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      sqrt_q <= req_i.sqrt;
      neg_q  <= req_i.num[31];
      zero_q <= req_i.den == 32'd0;
      den_q  <= req_i.den;
      rem_q  <= '0;
      root_q <= '0;
      sh_q   <= req_i.sqrt ? req_i.rad : {mag, 32'd0};
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        res_q <= fin;
      end else if (sqrt_q) begin
        rem_q  <= ges ? (r2s - trial) : r2s;
        root_q <= {root_q[30:0], ges};
        sh_q   <= {sh_q[61:0], 2'b00};
      end else begin
        rem_q <= {2'b00, (ged ? (r2d - {1'b0, den_q}) : r2d)};
        sh_q  <= {sh_q[62:0], ged};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

// File: rtl/cir_mem.sv
// Body table: velocity and property memories, one address, registered read.
`default_nettype none
module cir_mem
  import cir_pkg::*;
#(
  parameter int BODY_COUNT = BODY_COUNT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic [$clog2(BODY_COUNT)-1:0] addr_i,
  input  wire logic                          vel_we_i,
  input  wire vel_t                          vel_wdata_i,
  input  wire logic                          prop_we_i,
  input  wire prop_t                         prop_wdata_i,
  output vel_t                               vel_rdata_o,
  output prop_t                              prop_rdata_o
);

  vel_t  vel_mem  [BODY_COUNT];
  prop_t prop_mem [BODY_COUNT];

  always_ff @(posedge clk_i) begin
    if (vel_we_i) begin
      vel_mem[addr_i] <= vel_wdata_i;
    end
    vel_rdata_o <= vel_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (prop_we_i) begin
      prop_mem[addr_i] <= prop_wdata_i;
    end
    prop_rdata_o <= prop_mem[addr_i];
  end

endmodule
`default_nettype wire

// File: rtl/contact_impulse_resolver.sv
// Contact impulse resolver: command sequencer around a shared multiplier and divide/sqrt unit.
// Writes return no result; a read returns its result from ST_OUTA, after the table reads in
// ST_RDB and ST_LATB. A contact runs up to five divides and one square root on the iterative
// unit, plus lane multiplies on the multiplier.
// No new transfer is accepted until the last result of the command has been taken.
// Reset clears the sequencer and sets friction_threshold to 328; the body table is not cleared.
`default_nettype none
module contact_impulse_resolver
  import cir_pkg::*;
#(
  parameter int BODY_COUNT = BODY_COUNT_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // body_a, body_b, vec_x, vec_y, vec_z, mass_in, restitution_in, static_friction_in,
  // dynamic_friction_in, movable_in, 3 pad bits
  input  wire logic [199:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // body_out, vel_out_x, vel_out_y, vel_out_z
  output logic [103:0]      m_axis_tdata,
  // outcome
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [16:0]  cfg_data_i
);

  localparam int AW = $clog2(BODY_COUNT);

  function automatic logic [AW-1:0] body_idx(input logic [7:0] x);
    logic [19:0] r;
    r = {12'd0, x};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (20'(BODY_COUNT) << k)) begin
        r = r - (20'(BODY_COUNT) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic fric_q, fric_d, started_q, started_d;
  logic [16:0] thr_q;

  cmd_e cmd_q;
  oc_e oc_q;
  logic [AW-1:0] a_q, b_q, in_a, in_b, mem_addr;
  logic same_q;
  logic signed [31:0] n_q [3];
  logic signed [31:0] va_q [3];
  logic signed [31:0] vb_q [3];
  logic signed [31:0] gf_q [3];
  logic signed [31:0] g_q [3];
  logic signed [31:0] tan_q [3];
  logic signed [31:0] t_q [3];
  logic signed [31:0] d_q [3];
  logic signed [31:0] w1_c [3];
  logic signed [31:0] w2_c [3];
  logic signed [31:0] g_c [3];
  logic signed [31:0] gf_c [3];
  prop_t pa_q, pb_q;
  logic signed [34:0] acc_q;
  logic [63:0] sq_q;
  logic signed [31:0] tmp_q, dn_q, j_q, jt_q, len_q;
  logic [30:0] m1_q, m2_q;
  logic [31:0] msum_q;
  logic [16:0] e_q;
  logic [17:0] sf_q, df_q;
  logic cond_q;

  logic in_fire, lane_last;
  logic [1:0] li_iss, li_con;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] mul_q, dot_fin, push_a_c, push_b_c;
  logic [63:0] mul_raw;
  logic [32:0] ajt;
  itu_req_t itu_req;
  itu_rsp_t itu_rsp;
  logic vel_we, prop_we;
  vel_t vel_wdata, vel_rd;
  prop_t prop_wdata, prop_rd;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_a = body_idx(s_axis_tdata[7:0]);
  assign in_b = body_idx(s_axis_tdata[15:8]);
  assign lane_last = cnt_q == 2'd3;
  assign li_iss = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign li_con = (cnt_q == 2'd0) ? 2'd0 : cnt_q - 2'd1;
  assign dot_fin = sat32(acc_q + sx35(mul_q));
  assign push_a_c = sat32(sx35(va_q[li_con]) - sx35(mul_q));
  assign push_b_c = sat32(sx35(vb_q[li_con]) + sx35(mul_q));
  assign ajt = jt_q[31] ? (~sx33(jt_q) + 33'd1) : {1'b0, jt_q};
  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w1_c[i] = pa_q.movable ? va_q[i] : sat32(-sx35(vb_q[i]));
      w2_c[i] = pb_q.movable ? vb_q[i] : sat32(-sx35(va_q[i]));
      g_c[i]  = sat32(sx35(w2_c[i]) - sx35(w1_c[i]));
      gf_c[i] = sat32(sx35(vb_q[i]) - sx35(va_q[i]));
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DN:    begin mul_a = sx33(n_q[li_iss]);   mul_b = sx33(gf_q[li_iss]); end
      ST_DNG:   begin mul_a = sx33(n_q[li_iss]);   mul_b = sx33(g_q[li_iss]); end
      ST_JM:    begin mul_a = Q_ONE + $signed({16'd0, e_q}); mul_b = sx33(tmp_q); end
      ST_DJ:    begin mul_a = sx33(n_q[li_iss]);   mul_b = sx33(j_q); end
      ST_PUSHA: begin mul_a = sx33(d_q[li_iss]);   mul_b = $signed({2'b00, m2_q}); end
      ST_PUSHB: begin mul_a = sx33(d_q[li_iss]);   mul_b = $signed({2'b00, m1_q}); end
      ST_TAN:   begin mul_a = sx33(n_q[li_iss]);   mul_b = sx33(dn_q); end
      ST_SQ:    begin mul_a = sx33(tan_q[li_iss]); mul_b = sx33(tan_q[li_iss]); end
      ST_DOT:   begin mul_a = sx33(gf_q[li_iss]);  mul_b = sx33(t_q[li_iss]); end
      ST_LIM:   begin mul_a = sx33(j_q);           mul_b = $signed({15'd0, sf_q}); end
      ST_FR1:   begin
        mul_a = sx33(t_q[li_iss]);
        mul_b = cond_q ? sx33(jt_q) : sx33(j_q);
      end
      ST_FR2:   begin mul_a = sx33(d_q[li_iss]);   mul_b = $signed({15'd0, df_q}); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  cir_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .q_o   (mul_q),
    .raw_o (mul_raw)
  );

  cir_itu u_itu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (itu_req),
    .rsp_o  (itu_rsp)
  );

  cir_mem #(.BODY_COUNT(BODY_COUNT)) u_mem (
    .clk_i        (clk_i),
    .addr_i       (mem_addr),
    .vel_we_i     (vel_we),
    .vel_wdata_i  (vel_wdata),
    .prop_we_i    (prop_we),
    .prop_wdata_i (prop_wdata),
    .vel_rdata_o  (vel_rd),
    .prop_rdata_o (prop_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      fric_q    <= 1'b0;
      started_q <= 1'b0;
      thr_q     <= THR_RESET;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      fric_q    <= fric_d;
      started_q <= started_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    fric_d = fric_q;
    started_d = started_q;
    itu_req.start = 1'b0;
    itu_req.sqrt = 1'b0;
    itu_req.num = tmp_q;
    itu_req.den = msum_q;
    itu_req.rad = sq_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tlast = 1'b1;
    mem_addr = a_q;
    vel_we = 1'b0;
    prop_we = 1'b0;
    vel_wdata = {va_q[2], va_q[1], va_q[0]};
    prop_wdata = s_axis_tdata[196:112];
    m_axis_tdata = {va_q[2], va_q[1], va_q[0], 8'(a_q)};
    m_axis_tuser = oc_q;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_addr = in_a;
        fric_d = 1'b0;
        vel_wdata = s_axis_tdata[111:16];
        if (in_fire) begin
          unique case (cmd_e'(s_axis_tuser))
            CMD_WR_VEL:  vel_we = 1'b1;
            CMD_WR_PROP: prop_we = 1'b1;
            default:     state_d = ST_RDB;
          endcase
        end
      end
      ST_RDB: begin
        mem_addr = b_q;
        state_d = ST_LATB;
      end
      ST_LATB: state_d = (cmd_q == CMD_READ) ? ST_OUTA : ST_G;
      ST_G: state_d = ST_DN;
      ST_DN: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) state_d = (dot_fin > 32'sd0) ? ST_WBA : ST_DNG;
      end
      ST_DNG: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) state_d = ST_JM;
      end
      ST_JM, ST_LIM: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd1) begin
          cnt_d = '0;
          state_d = (state_q == ST_JM) ? ST_JDIV : ST_FR1;
        end
      end
      ST_JDIV, ST_JTDIV, ST_SQRT, ST_TDIV: begin
        itu_req.sqrt = state_q == ST_SQRT;
        if (state_q == ST_TDIV) begin
          itu_req.num = tan_q[li_iss];
          itu_req.den = len_q;
        end
        if (!started_q) begin
          itu_req.start = 1'b1;
          started_d = 1'b1;
        end else if (itu_rsp.done) begin
          started_d = 1'b0;
          unique case (state_q)
            ST_JDIV:  state_d = ST_DJ;
            ST_JTDIV: state_d = ST_LIM;
            ST_SQRT:  state_d = (itu_rsp.res < $signed({15'd0, thr_q})) ? ST_WBA : ST_TDIV;
            default: begin
              cnt_d = cnt_q + 2'd1;
              if (cnt_q == 2'd2) begin
                cnt_d = '0;
                state_d = ST_DOT;
              end
            end
          endcase
        end
      end
      ST_DJ: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) state_d = ST_PUSHA;
      end
      ST_PUSHA: begin
        if (!pa_q.movable) begin
          state_d = ST_PUSHB;
        end else begin
          cnt_d = cnt_q + 2'd1;
          if (lane_last) state_d = ST_PUSHB;
        end
      end
      ST_PUSHB: begin
        if (!pb_q.movable) begin
          state_d = fric_q ? ST_WBA : ST_TAN;
        end else begin
          cnt_d = cnt_q + 2'd1;
          if (lane_last) state_d = fric_q ? ST_WBA : ST_TAN;
        end
      end
      ST_TAN: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) state_d = ST_SQ;
      end
      ST_SQ: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) state_d = ST_SQRT;
      end
      ST_DOT: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) state_d = ST_JTDIV;
      end
      ST_FR1: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) begin
          state_d = cond_q ? ST_PUSHA : ST_FR2;
          fric_d = 1'b1;
        end
      end
      ST_FR2: begin
        cnt_d = cnt_q + 2'd1;
        if (lane_last) state_d = ST_PUSHA;
      end
      ST_WBA: begin
        vel_we = 1'b1;
        state_d = ST_WBB;
      end
      ST_WBB: begin
        mem_addr = b_q;
        vel_we = 1'b1;
        vel_wdata = {vb_q[2], vb_q[1], vb_q[0]};
        state_d = ST_OUTA;
      end
      ST_OUTA: begin
        m_axis_tvalid = 1'b1;
        m_axis_tlast = cmd_q == CMD_READ;
        if (m_axis_tready) state_d = (cmd_q == CMD_READ) ? ST_IDLE : ST_OUTB;
      end
      ST_OUTB: begin
        m_axis_tvalid = 1'b1;
        m_axis_tdata = {vb_q[2], vb_q[1], vb_q[0], 8'(b_q)};
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_q  <= cmd_e'(s_axis_tuser);
          a_q    <= in_a;
          b_q    <= in_b;
          same_q <= in_a == in_b;
          n_q[0] <= s_axis_tdata[47:16];
          n_q[1] <= s_axis_tdata[79:48];
          n_q[2] <= s_axis_tdata[111:80];
        end
      end
      ST_RDB: begin
        va_q[0] <= vel_rd.x;
        va_q[1] <= vel_rd.y;
        va_q[2] <= vel_rd.z;
        pa_q    <= prop_rd;
      end
      ST_LATB: begin
        vb_q[0] <= vel_rd.x;
        vb_q[1] <= vel_rd.y;
        vb_q[2] <= vel_rd.z;
        pb_q    <= prop_rd;
        oc_q    <= OC_READ;
      end
      ST_G: begin
        for (int i = 0; i < 3; i++) begin
          g_q[i]  <= g_c[i];
          gf_q[i] <= gf_c[i];
        end
        m1_q   <= pa_q.movable ? pa_q.mass : pb_q.mass;
        m2_q   <= pb_q.movable ? pb_q.mass : pa_q.mass;
        msum_q <= {1'b0, (pa_q.movable ? pa_q.mass : pb_q.mass)}
                + {1'b0, (pb_q.movable ? pb_q.mass : pa_q.mass)};
        e_q    <= (pa_q.rest < pb_q.rest) ? pa_q.rest : pb_q.rest;
        sf_q   <= 18'(({1'b0, pa_q.sf} + {1'b0, pb_q.sf}) >> 1);
        df_q   <= 18'(({1'b0, pa_q.df} + {1'b0, pb_q.df}) >> 1);
      end
      ST_DN, ST_DNG, ST_DOT: begin
        acc_q <= (cnt_q == 2'd0) ? '0 : acc_q + sx35(mul_q);
        if (lane_last) begin
          if (state_q == ST_DN) begin
            dn_q <= dot_fin;
            oc_q <= (dot_fin > 32'sd0) ? OC_SEP : OC_REFL;
          end else if (state_q == ST_DNG) begin
            tmp_q <= dot_fin;
          end else begin
            tmp_q <= sat32(-sx35(dot_fin));
          end
        end
      end
      ST_JM: begin
        if (cnt_q == 2'd1) tmp_q <= sat32(-sx35(mul_q));
      end
      ST_JDIV: begin
        if (started_q && itu_rsp.done) j_q <= itu_rsp.res;
      end
      ST_JTDIV: begin
        if (started_q && itu_rsp.done) jt_q <= itu_rsp.res;
      end
      ST_SQRT: begin
        if (started_q && itu_rsp.done) begin
          len_q <= itu_rsp.res;
          oc_q  <= (itu_rsp.res < $signed({15'd0, thr_q})) ? OC_REFL : OC_FRIC;
        end
      end
      ST_TDIV: begin
        if (started_q && itu_rsp.done) t_q[li_iss] <= itu_rsp.res;
      end
      ST_DJ, ST_FR1: begin
        if (cnt_q != 2'd0) d_q[li_con] <= mul_q;
      end
      ST_FR2: begin
        if (cnt_q != 2'd0) d_q[li_con] <= sat32(-sx35(mul_q));
      end
      ST_PUSHA: begin
        if (pa_q.movable && cnt_q != 2'd0) begin
          va_q[li_con] <= push_a_c;
          if (same_q) vb_q[li_con] <= push_a_c;
        end
      end
      ST_PUSHB: begin
        if (pb_q.movable && cnt_q != 2'd0) begin
          vb_q[li_con] <= push_b_c;
          if (same_q) va_q[li_con] <= push_b_c;
        end
      end
      ST_TAN: begin
        if (cnt_q != 2'd0) tan_q[li_con] <= sat32(sx35(gf_q[li_con]) - sx35(mul_q));
      end
      ST_SQ: begin
        sq_q <= (cnt_q == 2'd0) ? '0 : sq_q + mul_raw;
      end
      ST_LIM: begin
        if (cnt_q == 2'd1) cond_q <= $signed({1'b0, ajt}) <= $signed({{2{mul_q[31]}}, mul_q});
      end
      default: begin
      end
    endcase
  end

  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_second_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("contact result for body b missing");

  a_itu_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    itu_rsp.done |-> (started_q && (state_q == ST_JDIV || state_q == ST_JTDIV ||
                      state_q == ST_SQRT || state_q == ST_TDIV)))
    else $error("iterative unit finished outside a wait state");

  a_read_goes_to_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser == CMD_CONTACT || s_axis_tuser == CMD_READ)) |=>
      state_q == ST_RDB)
    else $error("read or contact did not start a table read");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for contact_impulse_resolver: directed and random commands.
module tb;
  import cir_pkg::*;

  typedef struct {
    cmd_e               cmd;
    logic [7:0]         a;
    logic [7:0]         b;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        mass;
    logic [16:0]        rest;
    logic [17:0]        sf;
    logic [17:0]        df;
    logic               mov;
  } body_cmd_t;

  typedef struct {
    logic [7:0]         body;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    oc_e                oc;
    logic               last;
  } body_vel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [199:0] s_data = '0;
  logic [1:0] s_user = '0;
  logic m_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [16:0] cfg_data = '0;
  wire s_ready, m_valid, m_last, cfg_ready;
  wire [103:0] m_data;
  wire [1:0] m_user;

  contact_impulse_resolver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // predictor copy of the body table
  logic signed [31:0] vel_tab [256][3];
  longint mass_tab [256];
  longint rest_tab [256];
  longint sf_tab [256];
  longint df_tab [256];
  bit mov_tab [256];
  bit vel_ok [256];
  bit prop_ok [256];
  longint thr = 328;

  body_vel_t vel_q[$];
  int errors = 0;
  int burst_left = 0;
  int hold_len = 0;

  initial forever #4 clk_i = ~clk_i;

  function automatic longint s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qm(longint p, longint q);
    return s32((p * q) >>> 16);
  endfunction

  function automatic longint qd(longint p, longint q);
    if (q == 0) return 0;
    return s32((p * 65536) / q);
  endfunction

  function automatic longint dot3(input longint p[3], input longint q[3]);
    return s32(qm(p[0], q[0]) + qm(p[1], q[1]) + qm(p[2], q[2]));
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic void apply_impulse(int k, input longint d[3], longint m, int sgn);
    longint p;
    for (int i = 0; i < 3; i++) begin
      p = qm(d[i], m);
      vel_tab[k][i] = 32'(s32(sgn > 0 ? vel_tab[k][i] + p : vel_tab[k][i] - p));
    end
  endfunction

  function automatic oc_e resolve_contact(int a, int b, input longint n[3]);
    longint v1[3], v2[3], w1[3], w2[3], g[3], gf[3], tn[3], t[3], d[3];
    longint m1, m2, msum, e, j, dn, len, jt, ajt, sf, df;
    longint unsigned sq;
    bit dy1, dy2;
    dy1 = mov_tab[a];
    dy2 = mov_tab[b];
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      v1[i] = vel_tab[a][i];
      v2[i] = vel_tab[b][i];
    end
    for (int i = 0; i < 3; i++) begin
      w1[i] = dy1 ? v1[i] : s32(-v2[i]);
      w2[i] = dy2 ? v2[i] : s32(-v1[i]);
      g[i] = s32(w2[i] - w1[i]);
      gf[i] = s32(v2[i] - v1[i]);
    end
    dn = dot3(n, gf);
    if (dn > 0) return OC_SEP;
    m1 = dy1 ? mass_tab[a] : mass_tab[b];
    m2 = dy2 ? mass_tab[b] : mass_tab[a];
    msum = m1 + m2;
    e = rest_tab[a] < rest_tab[b] ? rest_tab[a] : rest_tab[b];
    j = qd(s32(-qm(65536 + e, dot3(n, g))), msum);
    for (int i = 0; i < 3; i++) d[i] = qm(n[i], j);
    if (dy1) apply_impulse(a, d, m2, -1);
    if (dy2) apply_impulse(b, d, m1, 1);
    for (int i = 0; i < 3; i++) begin
      tn[i] = s32(gf[i] - qm(n[i], dn));
      sq += longint'(tn[i] * tn[i]);
    end
    len = s32(longint'(root64(sq)));
    if (len < thr) return OC_REFL;
    for (int i = 0; i < 3; i++) t[i] = qd(tn[i], len);
    jt = qd(s32(-dot3(gf, t)), msum);
    sf = (sf_tab[a] + sf_tab[b]) >> 1;
    df = (df_tab[a] + df_tab[b]) >> 1;
    ajt = jt < 0 ? -jt : jt;
    for (int i = 0; i < 3; i++) begin
      if (ajt <= qm(j, sf)) d[i] = qm(t[i], jt);
      else d[i] = s32(-qm(qm(t[i], j), df));
    end
    if (dy1) apply_impulse(a, d, m2, -1);
    if (dy2) apply_impulse(b, d, m1, 1);
    return OC_FRIC;
  endfunction

  function automatic void push_report(int k, oc_e oc, logic last);
    body_vel_t r;
    r.body = 8'(k);
    r.x = vel_tab[k][0];
    r.y = vel_tab[k][1];
    r.z = vel_tab[k][2];
    r.oc = oc;
    r.last = last;
    vel_q.push_back(r);
  endfunction

  function automatic void predict_cmd(body_cmd_t c);
    longint n[3];
    oc_e oc;
    case (c.cmd)
      CMD_WR_VEL: begin
        vel_tab[c.a][0] = c.x;
        vel_tab[c.a][1] = c.y;
        vel_tab[c.a][2] = c.z;
        vel_ok[c.a] = 1'b1;
      end
      CMD_WR_PROP: begin
        mass_tab[c.a] = c.mass;
        rest_tab[c.a] = c.rest;
        sf_tab[c.a] = c.sf;
        df_tab[c.a] = c.df;
        mov_tab[c.a] = c.mov;
        prop_ok[c.a] = 1'b1;
      end
      CMD_CONTACT: begin
        n[0] = c.x;
        n[1] = c.y;
        n[2] = c.z;
        oc = resolve_contact(c.a, c.b, n);
        push_report(c.a, oc, 1'b0);
        push_report(c.b, oc, 1'b1);
      end
      default: push_report(c.a, OC_READ, 1'b1);
    endcase
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_cmd(body_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user <= c.cmd;
    s_data <= {3'b000, c.mov, c.df, c.sf, c.rest, c.mass, c.z, c.y, c.x, c.b, c.a};
    do @(posedge clk_i); while (!s_ready);
    predict_cmd(c);
  endtask

  function automatic body_cmd_t blank_cmd(cmd_e cmd, int a, int b);
    body_cmd_t c;
    c.cmd = cmd;
    c.a = 8'(a);
    c.b = 8'(b);
    c.x = $urandom;
    c.y = $urandom;
    c.z = $urandom;
    c.mass = 31'($urandom_range(1, 32'h7fff_ffff));
    c.rest = 17'($urandom_range(0, 65536));
    c.sf = 18'($urandom_range(0, 131072));
    c.df = 18'($urandom_range(0, 131072));
    c.mov = $urandom_range(0, 1);
    return c;
  endfunction

  task automatic wr_vel(int k, logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [31:0] z);
    body_cmd_t c;
    c = blank_cmd(CMD_WR_VEL, k, $urandom_range(0, 255));
    c.x = x;
    c.y = y;
    c.z = z;
    send_cmd(c);
  endtask

  task automatic wr_prop(int k, int mass, int rest, int sf, int df, bit mov);
    body_cmd_t c;
    c = blank_cmd(CMD_WR_PROP, k, $urandom_range(0, 255));
    c.mass = 31'(mass);
    c.rest = 17'(rest);
    c.sf = 18'(sf);
    c.df = 18'(df);
    c.mov = mov;
    send_cmd(c);
  endtask

  task automatic hit(int a, int b, logic signed [31:0] x, logic signed [31:0] y,
                     logic signed [31:0] z);
    body_cmd_t c;
    c = blank_cmd(CMD_CONTACT, a, b);
    c.x = x;
    c.y = y;
    c.z = z;
    send_cmd(c);
  endtask

  task automatic rd(int k);
    send_cmd(blank_cmd(CMD_READ, k, $urandom_range(0, 255)));
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (vel_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_threshold(int v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= 17'(v);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr = v;
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
    endcase
  endfunction

  function automatic body_cmd_t rand_normal(body_cmd_t c);
    int ax;
    case ($urandom_range(0, 9))
      0: begin
        c.x = $urandom;
        c.y = $urandom;
        c.z = $urandom;
      end
      1, 2, 3: begin
        ax = $urandom_range(0, 2);
        c.x = (ax == 0) ? 32'sd65536 : 32'sd0;
        c.y = (ax == 1) ? 32'sd65536 : 32'sd0;
        c.z = (ax == 2) ? 32'sd65536 : 32'sd0;
        if ($urandom_range(0, 1) != 0) begin
          c.x = -c.x;
          c.y = -c.y;
          c.z = -c.z;
        end
      end
      default: begin
        c.x = $signed(32'($urandom_range(0, 2 << 16))) - 65536;
        c.y = $signed(32'($urandom_range(0, 2 << 16))) - 65536;
        c.z = $signed(32'($urandom_range(0, 2 << 16))) - 65536;
      end
    endcase
    return c;
  endfunction

  function automatic int pick_body(bit need_prop);
    int k;
    k = $urandom_range(0, 255);
    if (!vel_ok[k] || (need_prop && !prop_ok[k])) k = $urandom_range(0, 15);
    return k;
  endfunction

  task automatic rand_cmd();
    body_cmd_t c;
    int sel, k;
    sel = $urandom_range(0, 99);
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    if (sel < 15) begin
      c = blank_cmd(CMD_WR_VEL, k, $urandom_range(0, 255));
      c.x = rand_vel();
      c.y = rand_vel();
      c.z = rand_vel();
    end else if (sel < 27) begin
      c = blank_cmd(CMD_WR_PROP, k, $urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) c.mass = 31'($urandom_range(1 << 13, 16 << 16));
      if ($urandom_range(0, 2) != 0) c.mov = 1'b1;
    end else if (sel < 40) begin
      c = blank_cmd(CMD_READ, pick_body(1'b0), $urandom_range(0, 255));
    end else begin
      c = blank_cmd(CMD_CONTACT, pick_body(1'b1), pick_body(1'b1));
      if ($urandom_range(0, 19) == 0) c.b = c.a;
      c = rand_normal(c);
    end
    send_cmd(c);
  endtask

  task automatic test_setup();
    for (int k = 0; k < 16; k++) begin
      wr_vel(k, rand_vel(), rand_vel(), rand_vel());
      wr_prop(k, $urandom_range(1 << 14, 8 << 16), $urandom_range(0, 65536),
              $urandom_range(0, 131072), $urandom_range(0, 131072), k < 12);
    end
  endtask

  task automatic test_directed();
    wr_vel(0, 32'sd65536, 32'sd0, 32'sd0);
    wr_vel(1, -32'sd65536, 32'sd32768, 32'sd0);
    wr_prop(0, 65536, 65536, 131072, 131072, 1'b1);
    wr_prop(1, 65536, 0, 0, 0, 1'b1);
    hit(0, 1, 32'sd65536, 32'sd0, 32'sd0);
    hit(0, 1, -32'sd65536, 32'sd0, 32'sd0);
    hit(0, 12, 32'sd65536, 32'sd0, 32'sd0);
    hit(12, 13, 32'sd0, 32'sd65536, 32'sd0);
    hit(2, 2, 32'sd0, 32'sd0, 32'sd65536);
    wr_vel(255, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    wr_prop(255, 32'h7fff_ffff, 65536, 131072, 131072, 1'b1);
    wr_vel(254, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    wr_prop(254, 1, 0, 0, 131072, 1'b1);
    hit(255, 254, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    hit(254, 255, 32'sd65536, 32'sd65536, 32'sd65536);
    rd(255);
    rd(254);
    rd(0);
  endtask

  task automatic test_threshold_extremes();
    set_threshold(0);
    wr_vel(3, 32'sd65536, 32'sd0, 32'sd0);
    wr_vel(4, -32'sd65536, 32'sd0, 32'sd0);
    hit(3, 4, 32'sd65536, 32'sd0, 32'sd0);
    repeat (100) rand_cmd();
    set_threshold(65536);
    repeat (100) rand_cmd();
  endtask

  task automatic test_random(int count);
    set_threshold($urandom_range(0, 65536));
    repeat (count) rand_cmd();
  endtask

  task automatic test_backpressure();
    hold_len = 3000;
    repeat (40) rand_cmd();
  endtask

  // receiver: ready pattern switching between modes, plus a long hold on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(64, 512);
      end
      left--;
      if (hold_len > 0) begin
        hold_len--;
        m_ready <= 1'b0;
      end else begin
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= ($urandom_range(0, 1) != 0);
          default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    body_vel_t w;
    if (m_valid && m_ready) begin
      if (vel_q.size() == 0) begin
        $display("%0t: unexpected transfer body=%0d", $time, m_data[7:0]);
        errors++;
      end else begin
        w = vel_q.pop_front();
        if (m_data[7:0] !== w.body || m_data[39:8] !== w.x || m_data[71:40] !== w.y
            || m_data[103:72] !== w.z || m_user !== w.oc || m_last !== w.last) begin
          $display("%0t: mismatch expected body=%0d v=(%0d,%0d,%0d) oc=%0d last=%0b",
                   $time, w.body, w.x, w.y, w.z, w.oc, w.last);
          $display("%0t:          actual body=%0d v=(%0d,%0d,%0d) oc=%0d last=%0b",
                   $time, m_data[7:0], $signed(m_data[39:8]), $signed(m_data[71:40]),
                   $signed(m_data[103:72]), m_user, m_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #(8 * 4_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_setup();
    test_directed();
    repeat (120) rand_cmd();
    test_threshold_extremes();
    test_random(200);
    test_backpressure();
    test_random(200);
    settle();
    repeat (400) @(posedge clk_i);
    if (vel_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: contact_impulse_resolver.f
rtl/cir_pkg.sv
rtl/cir_mul.sv
rtl/cir_itu.sv
rtl/cir_mem.sv
rtl/contact_impulse_resolver.sv
tb/tb.sv
